FILE: rtl/pmt_pkg.sv
`timescale 1ns / 1ps
package pmt_pkg;

  localparam int NUM_PAIRS   = 64;
  localparam int HITS_W      = 64;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int STRETCH_W   = 5;
  localparam int TICK_W      = 16;
  localparam int COUNT_W     = 7;
  localparam int GRP_SIZE    = 8;
  localparam int NUM_GRPS    = (NUM_PAIRS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GRP_CNT_W   = $clog2(GRP_SIZE + 1);
  localparam int PAD_W       = NUM_GRPS * GRP_SIZE;

  localparam logic [STRETCH_W-1:0] STRETCH_RESET = STRETCH_W'(11);
  localparam logic [TICK_W-1:0]    WIN_END_RESET = TICK_W'(225);
  localparam logic [TICK_W-1:0]    TICK_MAX      = {TICK_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAIR_AND      = 3'd0,
    REG_SINGLE_MASK   = 3'd1,
    REG_STRETCH_TICKS = 3'd2,
    REG_WINDOW_FIRST  = 3'd3,
    REG_WINDOW_END    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic                 accept;
    logic                 start;
    logic                 pair_and;
    logic [STRETCH_W-1:0] stretch;
  } lane_ctl_t;

  typedef struct packed {
    logic valid;
    logic in_win;
    logic start;
  } tick_ctl_t;

endpackage

FILE: rtl/pmt_if.sv
`timescale 1ns / 1ps
interface pmt_hits_if;
  logic                      valid;
  logic                      ready;
  logic [pmt_pkg::HITS_W-1:0] first_hits;
  logic [pmt_pkg::HITS_W-1:0] second_hits;
  logic                      event_start;

  modport source (output valid, first_hits, second_hits, event_start, input ready);
  modport sink   (input valid, first_hits, second_hits, event_start, output ready);
endinterface

interface pmt_count_if;
  logic                        valid;
  logic                        ready;
  logic [pmt_pkg::COUNT_W-1:0] pairs_on;
  logic                        in_window;
  logic [pmt_pkg::COUNT_W-1:0] window_max;

  modport source (output valid, pairs_on, in_window, window_max, input ready);
  modport sink   (input valid, pairs_on, in_window, window_max, output ready);
endinterface

FILE: rtl/pmt_lane.sv
`timescale 1ns / 1ps
module pmt_lane (
  input  logic               clk,
  input  logic               rst,
  input  pmt_pkg::lane_ctl_t ctl,
  input  logic               first_hit,
  input  logic               second_hit,
  input  logic               single,
  output logic               high
);
  import pmt_pkg::*;

  logic [STRETCH_W-1:0] hold_count;
  logic [STRETCH_W-1:0] hold_count_next;
  logic                 high_next;
  logic [STRETCH_W-1:0] hold_cur;
  logic                 prev_cur;
  logic                 raw;

  always_comb begin
    raw      = single ? first_hit
                      : (ctl.pair_and ? (first_hit & second_hit) : (first_hit | second_hit));
    hold_cur = ctl.start ? '0 : hold_count;
    prev_cur = ctl.start ? 1'b0 : high;
    if (hold_cur != '0) begin
      high_next       = 1'b1;
      hold_count_next = hold_cur - STRETCH_W'(1);
    end else if (raw && !prev_cur) begin
      high_next       = 1'b1;
      hold_count_next = ctl.stretch;
    end else begin
      high_next       = raw;
      hold_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count <= '0;
      high       <= 1'b0;
    end else if (ctl.accept) begin
      hold_count <= hold_count_next;
      high       <= high_next;
    end
  end

endmodule

FILE: rtl/pmt_merge.sv
`timescale 1ns / 1ps
module pmt_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  pmt_pkg::tick_ctl_t            ctl,
  input  logic [pmt_pkg::NUM_PAIRS-1:0] pair_bits,
  output logic                          s_ready,
  pmt_count_if.source                   counts
);
  import pmt_pkg::*;

  logic                 v_b;
  logic                 inside_b;
  logic                 start_b;
  logic [GRP_CNT_W-1:0] grp_cnt [NUM_GRPS];
  logic [GRP_CNT_W-1:0] grp_cnt_next [NUM_GRPS];
  logic [COUNT_W-1:0]   running_max;
  logic [COUNT_W-1:0]   running_max_next;
  logic [COUNT_W-1:0]   sum;
  logic [PAD_W-1:0]     padded;
  logic                 ready_c;

  assign ready_c = !counts.valid || counts.ready;
  assign s_ready = !v_b || ready_c;
  assign padded  = PAD_W'(pair_bits);

  always_comb begin
    logic [GRP_CNT_W-1:0] acc;
    for (int g = 0; g < NUM_GRPS; g++) begin
      acc = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        acc = acc + GRP_CNT_W'(padded[g*GRP_SIZE + j]);
      end
      grp_cnt_next[g] = acc;
    end
  end

  always_comb begin
    logic [COUNT_W-1:0] base;
    sum = '0;
    for (int g = 0; g < NUM_GRPS; g++) begin
      sum = sum + COUNT_W'(grp_cnt[g]);
    end
    base = start_b ? '0 : running_max;
    running_max_next = (inside_b && (sum > base)) ? sum : base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else if (s_ready) begin
      v_b <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && ctl.valid) begin
      grp_cnt  <= grp_cnt_next;
      inside_b <= ctl.in_win;
      start_b  <= ctl.start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counts.valid <= 1'b0;
      running_max  <= '0;
    end else if (ready_c) begin
      counts.valid <= v_b;
      if (v_b) begin
        running_max <= running_max_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_c && v_b) begin
      counts.pairs_on   <= sum;
      counts.in_window  <= inside_b;
      counts.window_max <= running_max_next;
    end
  end

endmodule

FILE: rtl/pmt_pair_multiplicity_trigger_unit.sv
`timescale 1ns / 1ps
// Pair multiplicity trigger. Takes one discriminator tick per clock while the output is
// not stalled and returns one count item per accepted tick. Each pair has its own
// lane holding its stretch counter and last output, so ticks stream at one per cycle unless the output stalls;
// the pair count is summed by a two-stage registered adder tree behind the lane register.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must write it
// only while no item is in flight, as the block itself does not enforce this.
module pmt_pair_multiplicity_trigger_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pmt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pmt_pkg::CFG_W-1:0]     cfg_data,
  pmt_hits_if.sink                      ticks,
  pmt_count_if.source                   counts
);
  import pmt_pkg::*;

  logic                 pair_and;
  logic [HITS_W-1:0]    single_mask;
  logic [STRETCH_W-1:0] stretch_ticks;
  logic [TICK_W-1:0]    window_first;
  logic [TICK_W-1:0]    window_end;

  logic [TICK_W-1:0]    tick_index;
  logic [TICK_W-1:0]    tick_cur;
  logic                 v_a;
  logic                 inside_a;
  logic                 start_a;
  logic                 accept;
  logic                 ready_b;
  logic                 inside_now;
  lane_ctl_t            lane_ctl;
  tick_ctl_t            merge_ctl;
  logic [NUM_PAIRS-1:0] pair_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_and      <= 1'b0;
      single_mask   <= '0;
      stretch_ticks <= STRETCH_RESET;
      window_first  <= '0;
      window_end    <= WIN_END_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PAIR_AND:      pair_and      <= cfg_data[0];
        REG_SINGLE_MASK:   single_mask   <= cfg_data[HITS_W-1:0];
        REG_STRETCH_TICKS: stretch_ticks <= cfg_data[STRETCH_W-1:0];
        REG_WINDOW_FIRST:  window_first  <= cfg_data[TICK_W-1:0];
        REG_WINDOW_END:    window_end    <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign ticks.ready = !v_a || ready_b;
  assign accept      = ticks.valid && ticks.ready;
  assign tick_cur    = ticks.event_start ? '0 : tick_index;
  assign inside_now  = (tick_cur >= window_first) && (tick_cur < window_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_index <= '0;
    end else if (accept) begin
      tick_index <= (tick_cur != TICK_MAX) ? tick_cur + TICK_W'(1) : tick_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (ticks.ready) begin
      v_a <= ticks.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      inside_a <= inside_now;
      start_a  <= ticks.event_start;
    end
  end

  assign lane_ctl = '{accept:   accept,
                      start:    ticks.event_start,
                      pair_and: pair_and,
                      stretch:  stretch_ticks};

  for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_lane
    pmt_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctl        (lane_ctl),
      .first_hit  (ticks.first_hits[p]),
      .second_hit (ticks.second_hits[p]),
      .single     (single_mask[p]),
      .high       (pair_bits[p])
    );
  end

  assign merge_ctl = '{valid: v_a, in_win: inside_a, start: start_a};

  pmt_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .ctl       (merge_ctl),
    .pair_bits (pair_bits),
    .s_ready   (ready_b),
    .counts    (counts)
  );

endmodule

FILE: rtl/pmt_checker.sv
`timescale 1ns / 1ps
module pmt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pmt_pkg::COUNT_W-1:0] pairs_on,
  input logic                        in_window,
  input logic [pmt_pkg::COUNT_W-1:0] window_max
);
  import pmt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pairs_on)
      && $stable(in_window) && $stable(window_max))
    else $error("result item changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pairs_on <= COUNT_W'(NUM_PAIRS) && window_max <= COUNT_W'(NUM_PAIRS))
    else $error("count above number of pairs");

  a_max_covers: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_window |-> window_max >= pairs_on)
    else $error("window max below in-window count");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind pmt_pair_multiplicity_trigger_unit pmt_checker u_pmt_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (counts.valid),
  .out_ready  (counts.ready),
  .pairs_on   (counts.pairs_on),
  .in_window  (counts.in_window),
  .window_max (counts.window_max)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import pmt_pkg::*;

  typedef struct packed {
    logic [HITS_W-1:0] first;
    logic [HITS_W-1:0] second;
    logic              start;
  } tick_t;

  typedef struct packed {
    logic [COUNT_W-1:0] pairs_on;
    logic               in_window;
    logic [COUNT_W-1:0] window_max;
  } count_t;

  typedef enum int {SPARSE, MIXED, DENSE, QUIET, FULL, DRIFT} hit_style_t;

  localparam int MAX_IDLE = 17;
  localparam int LAT      = 3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  pmt_hits_if  ticks();
  pmt_count_if counts();

  pmt_pair_multiplicity_trigger_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ticks     (ticks),
    .counts    (counts)
  );

  always #5 clk = ~clk;

  // trigger model: configuration and per-event state
  logic                 m_and     = 1'b0;
  logic [HITS_W-1:0]    m_single  = '0;
  logic [STRETCH_W-1:0] m_stretch = STRETCH_RESET;
  logic [TICK_W-1:0]    m_first   = '0;
  logic [TICK_W-1:0]    m_end     = WIN_END_RESET;
  logic [HITS_W-1:0]    m_prev;
  logic [STRETCH_W-1:0] m_hold [NUM_PAIRS];
  logic [TICK_W-1:0]    m_tick;
  logic [COUNT_W-1:0]   m_max;

  tick_t  ticks_todo [$];
  count_t counts_due [$];

  bit     calm = 1'b0;
  bit     src_lively = 1'b0;
  bit     snk_lively = 1'b0;
  int     src_gap = 0;
  int     snk_hold = 0;
  int     errors = 0;
  tick_t  cur;

  function automatic void clear_event();
    m_prev = '0;
    for (int p = 0; p < NUM_PAIRS; p++) m_hold[p] = '0;
    m_tick = '0;
    m_max = '0;
  endfunction

  function automatic count_t trigger_tick(tick_t t);
    logic [HITS_W-1:0] now;
    logic              raw;
    logic              hi;
    int                n;
    count_t            r;
    if (t.start) clear_event();
    now = '0;
    n = 0;
    for (int p = 0; p < NUM_PAIRS; p++) begin
      if (m_single[p]) raw = t.first[p];
      else if (m_and) raw = t.first[p] & t.second[p];
      else raw = t.first[p] | t.second[p];
      if (m_hold[p] != '0) begin
        hi = 1'b1;
        m_hold[p] = m_hold[p] - 1'b1;
      end else if (raw && !m_prev[p]) begin
        hi = 1'b1;
        m_hold[p] = m_stretch;
      end else begin
        hi = raw;
      end
      now[p] = hi;
      n += hi;
    end
    m_prev = now;
    r.in_window = (m_tick >= m_first) && (m_tick < m_end);
    if (r.in_window && n > m_max) m_max = COUNT_W'(n);
    if (m_tick != TICK_MAX) m_tick = m_tick + 1'b1;
    r.pairs_on = COUNT_W'(n);
    r.window_max = m_max;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int idle_len(bit lively);
    if (calm) return 0;
    if (lively) return $urandom_range(0, MAX_IDLE);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_IDLE) : 0;
  endfunction

  function automatic logic [HITS_W-1:0] next_hits(logic [HITS_W-1:0] prev, hit_style_t sty);
    case (sty)
      SPARSE:  return rand64() & rand64() & rand64();
      MIXED:   return rand64();
      DENSE:   return rand64() | rand64();
      QUIET:   return '0;
      FULL:    return '1;
      default: return prev ^ (rand64() & rand64() & rand64() & rand64());
    endcase
  endfunction

  // tick driver
  always @(posedge clk) begin
    count_t pred;
    if (rst) begin
      ticks.valid <= 1'b0;
      ticks.first_hits <= '0;
      ticks.second_hits <= '0;
      ticks.event_start <= 1'b0;
      src_gap = 0;
    end else begin
      if (ticks.valid && ticks.ready) begin
        pred = trigger_tick(cur);
        counts_due = {counts_due, pred};
      end
      if (!ticks.valid || ticks.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          ticks.valid <= 1'b0;
        end else if (ticks_todo.size() > 0) begin
          cur = ticks_todo.pop_front();
          ticks.valid <= 1'b1;
          ticks.first_hits <= cur.first;
          ticks.second_hits <= cur.second;
          ticks.event_start <= cur.start;
          src_gap = idle_len(src_lively);
        end else begin
          ticks.valid <= 1'b0;
        end
      end
    end
  end

  // count monitor
  always @(posedge clk) begin
    count_t got;
    count_t exp_cnt;
    if (rst) begin
      counts.ready <= 1'b0;
      snk_hold = 0;
    end else begin
      if (counts.valid && counts.ready) begin
        got = '{pairs_on: counts.pairs_on, in_window: counts.in_window,
                window_max: counts.window_max};
        if (counts_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: count item with none expected: pairs_on %0d in_window %0b max %0d",
                     $realtime, got.pairs_on, got.in_window, got.window_max);
        end else begin
          exp_cnt = counts_due.pop_front();
          if (got !== exp_cnt) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch pairs_on %0d/%0d in_window %0b/%0b max %0d/%0d (exp/got)",
                       $realtime, exp_cnt.pairs_on, got.pairs_on, exp_cnt.in_window,
                       got.in_window, exp_cnt.window_max, got.window_max);
          end
        end
        snk_hold = idle_len(snk_lively);
      end
      if (snk_hold > 0) begin
        snk_hold--;
        counts.ready <= 1'b0;
      end else begin
        counts.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_PAIR_AND:      m_and = val[0];
      REG_SINGLE_MASK:   m_single = val;
      REG_STRETCH_TICKS: m_stretch = val[STRETCH_W-1:0];
      REG_WINDOW_FIRST:  m_first = val[TICK_W-1:0];
      REG_WINDOW_END:    m_end = val[TICK_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // unused upper data bits carry noise; one write goes to an unmapped index
  task automatic configure(logic a, logic [HITS_W-1:0] single, logic [STRETCH_W-1:0] stretch,
                           logic [TICK_W-1:0] wf, logic [TICK_W-1:0] we);
    logic [CFG_W-1:0] r;
    r = rand64();
    r[0] = a;
    write_reg(REG_PAIR_AND, r);
    write_reg(REG_SINGLE_MASK, single);
    r = rand64();
    r[STRETCH_W-1:0] = stretch;
    write_reg(REG_STRETCH_TICKS, r);
    r = rand64();
    r[TICK_W-1:0] = wf;
    write_reg(REG_WINDOW_FIRST, r);
    r = rand64();
    r[TICK_W-1:0] = we;
    write_reg(REG_WINDOW_END, r);
    write_reg(CFG_IDX_W'($urandom_range(REG_WINDOW_END + 1, (1 << CFG_IDX_W) - 1)), rand64());
    @(negedge clk);
  endtask

  task automatic settle();
    do @(negedge clk);
    while (ticks_todo.size() != 0 || counts_due.size() != 0 || ticks.valid);
  endtask

  task automatic push_tick(logic [HITS_W-1:0] f, logic [HITS_W-1:0] s, logic st);
    tick_t t;
    t = '{first: f, second: s, start: st};
    ticks_todo = {ticks_todo, t};
  endtask

  task automatic run_event(int len, hit_style_t sty);
    logic [HITS_W-1:0] f;
    logic [HITS_W-1:0] s;
    f = rand64();
    s = rand64();
    for (int i = 0; i < len; i++) begin
      f = next_hits(f, sty);
      s = next_hits(s, sty);
      push_tick(f, s, i == 0);
    end
  endtask

  task automatic run_phase(int items);
    int done;
    int len;
    done = 0;
    src_lively = $urandom_range(0, 1);
    snk_lively = $urandom_range(0, 1);
    while (done < items) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 40);
      run_event(len, hit_style_t'($urandom_range(SPARSE, DRIFT)));
      done += len;
    end
  endtask

  initial begin
    logic [HITS_W-1:0] single;
    logic [STRETCH_W-1:0] stretch;
    logic [TICK_W-1:0] wf;
    logic [TICK_W-1:0] we;
    ticks.valid = 1'b0;
    ticks.first_hits = '0;
    ticks.second_hits = '0;
    ticks.event_start = 1'b0;
    counts.ready = 1'b0;
    clear_event();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset configuration: OR, stretch 11, window 0..224
    push_tick('1, '0, 1'b1);
    push_tick('0, '0, 1'b0);
    push_tick('0, '1, 1'b0);
    push_tick('0, '0, 1'b1);
    push_tick({32{2'b10}}, {32{2'b01}}, 1'b0);
    push_tick({32{2'b01}}, '0, 1'b1);
    repeat (12) push_tick('0, '0, 1'b0);
    push_tick(64'h1, 64'h8000_0000_0000_0000, 1'b0);
    push_tick('1, '1, 1'b1);
    settle();

    // AND, no stretch, inverted window
    configure(1'b1, '0, '0, 16'd5, 16'd3);
    push_tick('1, '0, 1'b1);
    push_tick('1, '1, 1'b0);
    push_tick({32{2'b10}}, '1, 1'b0);
    push_tick('0, '0, 1'b0);
    settle();

    configure(1'b0, '1, '1, '0, TICK_MAX);
    run_phase(200);
    settle();

    configure(1'b1, rand64(), STRETCH_W'($urandom_range(1, 30)), 16'd10, 16'd10);
    run_phase(200);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 3))
        0: single = '0;
        1: single = '1;
        default: single = rand64();
      endcase
      case ($urandom_range(0, 3))
        0: stretch = '0;
        1: stretch = '1;
        default: stretch = STRETCH_W'($urandom_range(0, 31));
      endcase
      case ($urandom_range(0, 4))
        0: wf = '0;
        1: wf = TICK_MAX;
        default: wf = TICK_W'($urandom_range(0, 40));
      endcase
      case ($urandom_range(0, 4))
        0: we = '0;
        1: we = TICK_MAX;
        default: we = TICK_W'($urandom_range(0, 300));
      endcase
      configure($urandom_range(0, 1), single, stretch, wf, we);
      run_phase(160);
      settle();
    end

    // back to back, no idle cycles on either side
    configure($urandom_range(0, 1), rand64(), STRETCH_W'($urandom_range(0, 31)),
              TICK_W'($urandom_range(0, 20)), TICK_W'($urandom_range(20, 200)));
    calm = 1'b1;
    run_phase(120);
    settle();
    calm = 1'b0;

    configure($urandom_range(0, 1), rand64(), STRETCH_W'($urandom_range(0, 31)),
              TICK_W'($urandom_range(0, 20)), TICK_W'($urandom_range(20, 200)));
    run_phase(150);
    settle();

    repeat (4 * LAT) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/pmt_pkg.sv
rtl/pmt_if.sv
rtl/pmt_lane.sv
rtl/pmt_merge.sv
rtl/pmt_pair_multiplicity_trigger_unit.sv
rtl/pmt_checker.sv
tb/tb_top.sv
